// ----- rtl/sti_pkg.sv -----
// Shared types, constants and elaboration-time helpers of the sine table interpolator.
// Used by the channel interfaces and by sine_table_interpolator.
package sti_pkg;

   localparam int ANGLE_W      = 24;
   localparam int SINE_W       = 16;
   localparam int QBITS        = 61;
   localparam int SERIES_TERMS = 14;

   localparam logic [63:0]       PI_Q62  = 64'hC90F_DAA2_2168_C235;
   localparam logic [SINE_W-1:0] Q15_MAX = 16'h7FFF;
   localparam logic [SINE_W-1:0] Q15_MIN = 16'h8000;

   // fill sequencer: four partial products, accumulate, round, recurrence, store
   typedef enum logic [3:0] {
      FS_PP0,
      FS_PP1,
      FS_PP2,
      FS_PP3,
      FS_PPLAST,
      FS_ROUND,
      FS_SUB,
      FS_STORE,
      FS_DONE
   } fill_state_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_WORD,
      SH_DWORD
   } acc_shift_type;

   // (a*b) >> 61 rounded to nearest, low 64 bits kept; elaboration only
   function automatic logic [63:0] umul_shift_q61(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << (QBITS - 1));
      return p[QBITS+63:QBITS];
   endfunction

   // Taylor series of sin and cos in Q61, returned as {sin, cos}; elaboration only
   function automatic logic [127:0] sin_cos_q61(input logic [63:0] theta);
      logic [63:0] x2;
      logic [63:0] st;
      logic [63:0] ct;
      logic [63:0] s;
      logic [63:0] c;
      x2 = umul_shift_q61(theta, theta);
      st = theta;
      ct = 64'd1 << QBITS;
      s  = theta;
      c  = 64'd1 << QBITS;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         st = umul_shift_q61(st, x2) / 64'((2 * k) * (2 * k + 1));
         ct = umul_shift_q61(ct, x2) / 64'((2 * k - 1) * (2 * k));
         if ((k & 1) != 0) begin
            s = s - st;
            c = c - ct;
         end else begin
            s = s + st;
            c = c + ct;
         end
      end
      return {s, c};
   endfunction

endpackage

// ----- rtl/sti_req_if.sv -----
// Request channel of the sine table interpolator: one angle word per handshake.
// Depends on sti_pkg.
interface sti_req_if import sti_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink (input valid, input angle, output ready);
endinterface

// ----- rtl/sti_rsp_if.sv -----
// Response channel of the sine table interpolator: one Q1.15 sine word per handshake.
// Depends on sti_pkg.
interface sti_rsp_if import sti_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [SINE_W-1:0] sine_value;

   modport source (output valid, output sine_value, input ready);
   modport sink (input valid, input sine_value, output ready);
endinterface

// ----- rtl/sine_table_interpolator.sv -----
// Sine table with linear interpolation, table filled by an oscillator recurrence after reset.
// Depends on sti_pkg, sti_req_if and sti_rsp_if.
//
//  channel    | dir | word                          | handshake
//  req_chan   | in  | angle, 24 bit turn fraction   | valid/ready
//  rsp_chan   | out | sine_value, signed Q1.15      | valid/ready
//
// One angle per cycle sustained while rsp_chan.ready stays high.
// The five stages are index reduction (two), the dual table read, the slope multiply
// and the rounding add into the output register.
// After reset the table fill runs once through every table entry: each entry uses a
// 32x32 multiplier four times for the Q61 product. req_chan.ready is low until the fill ends.
// Stages advance whenever the stage ahead can move, so a stalled output only holds what
// is behind it once every stage is full.
module sine_table_interpolator import sti_pkg::*; #(
   parameter int TABLE_SIZE      = 1024,
   parameter int ANGLE_FRAC_BITS = 14
) (
   input  logic      clock,
   input  logic      reset,
   sti_req_if.sink   req_chan,
   sti_rsp_if.source rsp_chan
);

   localparam int F  = ANGLE_FRAC_BITS;
   localparam int IB = ANGLE_W - F;
   localparam int IW = (IB > 0) ? IB : 1;
   localparam int AW = $clog2(TABLE_SIZE);
   localparam int RW = IW + 18;
   localparam int PW = SINE_W + 2 + F;

   localparam logic [IW-1:0]  RECIP    = IW'((2 ** IW) / TABLE_SIZE);
   localparam logic [AW-1:0]  LAST_IDX = AW'(TABLE_SIZE - 1);
   localparam logic [63:0]    THETA    = (PI_Q62 + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
   localparam logic [127:0]   SIN_COS  = sin_cos_q61(THETA);
   localparam logic [63:0]    SIN_Q61  = SIN_COS[127:64];
   localparam logic [63:0]    BETA     = SIN_COS[63:0] + SIN_COS[63:0];
   localparam logic [63:0]    BETA_MAG = BETA[63] ? (64'd0 - BETA) : BETA;

   // ---------------------------------------------------------------- table
   logic [SINE_W-1:0] sine_store [TABLE_SIZE];

   // ---------------------------------------------------------------- fill
   fill_state_type fstate_ff, fstate_in;
   logic [AW-1:0]  fidx_ff;
   logic [63:0]    y1_ff, y2_ff;
   logic [63:0]    pp_ff;
   logic [127:0]   acc_ff;
   logic [63:0]    prod_ff;
   logic [63:0]    yn_ff, yn_in;

   logic           pp_en;
   logic [1:0]     pp_sel;
   logic           acc_clr;
   logic           acc_add;
   acc_shift_type  acc_sh;
   logic           round_en;
   logic           sub_en;
   logic           store_en;
   logic           fill_done;

   logic [63:0]    y1_mag;
   logic [31:0]    a_part, b_part;
   logic [127:0]   pp_shifted;
   logic [127:0]   acc_rnd;
   logic [63:0]    rnd;
   logic           prod_neg;
   logic           fidx_rec;
   logic [63:0]    yn_mag;
   logic [63:0]    yn_sum;
   logic [17:0]    q15_m;
   logic [SINE_W-1:0] q15_in;

   always_comb begin
      fstate_in = fstate_ff;
      case (fstate_ff)
         FS_PP0:    fstate_in = FS_PP1;
         FS_PP1:    fstate_in = FS_PP2;
         FS_PP2:    fstate_in = FS_PP3;
         FS_PP3:    fstate_in = FS_PPLAST;
         FS_PPLAST: fstate_in = FS_ROUND;
         FS_ROUND:  fstate_in = FS_SUB;
         FS_SUB:    fstate_in = FS_STORE;
         FS_STORE:  fstate_in = (fidx_ff == LAST_IDX) ? FS_DONE : FS_PP0;
         FS_DONE:   fstate_in = FS_DONE;
         default:   fstate_in = FS_PP0;
      endcase
   end

   always_comb begin
      pp_en     = 1'b0;
      pp_sel    = 2'b00;
      acc_clr   = 1'b0;
      acc_add   = 1'b0;
      acc_sh    = SH_NONE;
      round_en  = 1'b0;
      sub_en    = 1'b0;
      store_en  = 1'b0;
      fill_done = 1'b0;
      case (fstate_ff)
         FS_PP0: begin
            pp_en   = 1'b1;
            pp_sel  = 2'b00;
            acc_clr = 1'b1;
         end
         FS_PP1: begin
            pp_en   = 1'b1;
            pp_sel  = 2'b01;
            acc_add = 1'b1;
            acc_sh  = SH_NONE;
         end
         FS_PP2: begin
            pp_en   = 1'b1;
            pp_sel  = 2'b10;
            acc_add = 1'b1;
            acc_sh  = SH_WORD;
         end
         FS_PP3: begin
            pp_en   = 1'b1;
            pp_sel  = 2'b11;
            acc_add = 1'b1;
            acc_sh  = SH_WORD;
         end
         FS_PPLAST: begin
            acc_add = 1'b1;
            acc_sh  = SH_DWORD;
         end
         FS_ROUND:  round_en  = 1'b1;
         FS_SUB:    sub_en    = 1'b1;
         FS_STORE:  store_en  = 1'b1;
         FS_DONE:   fill_done = 1'b1;
         default: begin
         end
      endcase
   end

   always_comb begin
      y1_mag = y1_ff[63] ? (64'd0 - y1_ff) : y1_ff;
      // pp_sel = {beta high half, y1 high half}
      a_part = pp_sel[1] ? BETA_MAG[63:32] : BETA_MAG[31:0];
      b_part = pp_sel[0] ? y1_mag[63:32] : y1_mag[31:0];
      case (acc_sh)
         SH_NONE:  pp_shifted = {64'd0, pp_ff};
         SH_WORD:  pp_shifted = {32'd0, pp_ff, 32'd0};
         SH_DWORD: pp_shifted = {pp_ff, 64'd0};
         default:  pp_shifted = '0;
      endcase
      acc_rnd  = acc_ff + (128'd1 << (QBITS - 1));
      rnd      = acc_rnd[QBITS+63:QBITS];
      prod_neg = BETA[63] ^ y1_ff[63];
      fidx_rec = (fidx_ff != AW'(0)) && (fidx_ff != AW'(1));
      if (fidx_ff == AW'(0)) begin
         yn_in = 64'd0;
      end else if (fidx_ff == AW'(1)) begin
         yn_in = SIN_Q61;
      end else begin
         yn_in = prod_ff - y2_ff;
      end
      // Q61 to Q15, ties away from zero, saturated
      yn_mag = yn_ff[63] ? (64'd0 - yn_ff) : yn_ff;
      yn_sum = yn_mag + (64'd1 << (QBITS - 16));
      q15_m  = yn_sum[63:QBITS-15];
      if (yn_ff[63]) begin
         q15_in = (q15_m >= 18'd32768) ? Q15_MIN : SINE_W'(18'd0 - q15_m);
      end else begin
         q15_in = (q15_m > 18'd32767) ? Q15_MAX : q15_m[SINE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff <= FS_PP0;
         fidx_ff   <= '0;
         y1_ff     <= SIN_Q61;
         y2_ff     <= 64'd0;
      end else begin
         fstate_ff <= fstate_in;
         if (store_en && (fidx_ff != LAST_IDX)) begin
            fidx_ff <= fidx_ff + AW'(1);
         end
         if (sub_en && fidx_rec) begin
            y2_ff <= y1_ff;
            y1_ff <= yn_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pp_en) begin
         pp_ff <= {32'd0, a_part} * {32'd0, b_part};
      end
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (acc_add) begin
         acc_ff <= acc_ff + pp_shifted;
      end
      if (round_en) begin
         prod_ff <= prod_neg ? (64'd0 - rnd) : rnd;
      end
      if (sub_en) begin
         yn_ff <= yn_in;
      end
   end

   // ---------------------------------------------------------------- lookup pipeline
   logic [4:0]        v_ff;
   logic [4:0]        ld;
   logic              req_take;

   logic [IW-1:0]     raw_in;
   logic [2*IW-1:0]   qprod;
   logic [IW-1:0]     raw0_ff, q0_ff;
   logic [F-1:0]      frac0_ff;

   logic [RW-1:0]     r_full, r_corr;
   logic [AW-1:0]     idx1_in, nxt1_in;
   logic [AW-1:0]     idx1_ff, nxt1_ff;
   logic [F-1:0]      frac1_ff;

   logic [SINE_W-1:0] s0_ff, s1_ff;
   logic [F-1:0]      frac2_ff;

   logic signed [SINE_W:0] diff;
   logic signed [PW-1:0]   diff_x, frac_x, prod3_in;
   logic signed [PW-1:0]   prod3_ff;
   logic [SINE_W-1:0]      base3_ff;

   logic [PW-1:0]          pmag, psum, pshift;
   logic signed [PW-1:0]   base_x, res;
   logic [SINE_W-1:0]      out_ff, out_in;

   always_comb begin
      ld[4]    = !v_ff[4] || rsp_chan.ready;
      ld[3]    = !v_ff[3] || ld[4];
      ld[2]    = !v_ff[2] || ld[3];
      ld[1]    = !v_ff[1] || ld[2];
      ld[0]    = !v_ff[0] || ld[1];
      req_take = req_chan.valid && fill_done && ld[0];
   end

   assign req_chan.ready      = fill_done && ld[0];
   assign rsp_chan.valid      = v_ff[4];
   assign rsp_chan.sine_value = out_ff;

   // index reduction modulo TABLE_SIZE: reciprocal estimate, then one correction
   always_comb begin
      raw_in  = IW'(req_chan.angle >> F);
      qprod   = (2 * IW)'(raw_in) * (2 * IW)'(RECIP);
      r_full  = RW'(raw0_ff) - RW'(q0_ff) * RW'(TABLE_SIZE);
      r_corr  = (r_full >= RW'(TABLE_SIZE)) ? (r_full - RW'(TABLE_SIZE)) : r_full;
      idx1_in = AW'(r_corr);
      nxt1_in = (idx1_in == LAST_IDX) ? '0 : (idx1_in + AW'(1));
   end

   always_comb begin
      diff     = {s1_ff[SINE_W-1], s1_ff} - {s0_ff[SINE_W-1], s0_ff};
      diff_x   = PW'(diff);
      frac_x   = PW'({1'b0, frac2_ff});
      prod3_in = diff_x * frac_x;
   end

   always_comb begin
      pmag   = prod3_ff[PW-1] ? (PW'(0) - PW'(prod3_ff)) : PW'(prod3_ff);
      psum   = pmag + (PW'(1) << (F - 1));
      pshift = psum >> F;
      base_x = PW'(signed'(base3_ff));
      res    = prod3_ff[PW-1] ? (base_x - signed'(pshift)) : (base_x + signed'(pshift));
      out_in = res[SINE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[0]) begin
            v_ff[0] <= req_take;
         end
         if (ld[1]) begin
            v_ff[1] <= v_ff[0];
         end
         if (ld[2]) begin
            v_ff[2] <= v_ff[1];
         end
         if (ld[3]) begin
            v_ff[3] <= v_ff[2];
         end
         if (ld[4]) begin
            v_ff[4] <= v_ff[3];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         raw0_ff  <= raw_in;
         q0_ff    <= qprod[2*IW-1:IW];
         frac0_ff <= F'(req_chan.angle);
      end
      if (ld[1]) begin
         idx1_ff  <= idx1_in;
         nxt1_ff  <= nxt1_in;
         frac1_ff <= frac0_ff;
      end
      if (ld[2]) begin
         frac2_ff <= frac1_ff;
      end
      if (ld[3]) begin
         prod3_ff <= prod3_in;
         base3_ff <= s0_ff;
      end
      if (ld[4]) begin
         out_ff <= out_in;
      end
   end

   // table: written only by the fill, read at two addresses by the lookup
   always_ff @(posedge clock) begin
      if (store_en) begin
         sine_store[fidx_ff] <= q15_in;
      end
      if (ld[2]) begin
         s0_ff <= sine_store[idx1_ff];
         s1_ff <= sine_store[nxt1_ff];
      end
   end

endmodule

// ----- tb/sine_check.sv -----
// Scoreboard of the sine table interpolator: builds its own sine table, predicts each
// angle word's result and compares the response words in order. Depends on sti_pkg.
`timescale 1ns / 1ps

module sine_check import sti_pkg::*; #(
   parameter int TABLE_SIZE      = 1024,
   parameter int ANGLE_FRAC_BITS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [ANGLE_W-1:0]       req_angle,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [SINE_W-1:0] rsp_sine_value,
   output int                       fail_count,
   output int                       pending_count
);

   typedef struct {
      logic [ANGLE_W-1:0]       angle;
      logic signed [SINE_W-1:0] sine;
   } sine_due_type;

   logic signed [SINE_W-1:0] sine_rom [TABLE_SIZE];
   sine_due_type             sine_due [$];
   int                       fail_total;

   // (a*b) >> QBITS, rounded to nearest, low 64 bits kept
   function automatic logic [63:0] q61_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << (QBITS - 1));
      return p[QBITS+63:QBITS];
   endfunction

   function automatic logic [63:0] q61_mag(input logic [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   // signed product, ties away from zero
   function automatic logic [63:0] q61_smul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = q61_mul(q61_mag(a), q61_mag(b));
      return (a[63] != b[63]) ? (~r + 64'd1) : r;
   endfunction

   function automatic logic signed [SINE_W-1:0] q61_to_q15(input logic [63:0] y);
      logic [63:0] m;
      m = (q61_mag(y) + (64'd1 << (QBITS - 16))) >> (QBITS - 15);
      if (y[63]) begin
         if (m >= 64'd32768) return Q15_MIN;
         return SINE_W'(~m + 64'd1);
      end
      if (m > 64'd32767) return Q15_MAX;
      return SINE_W'(m);
   endfunction

   // oscillator recurrence seeded with a Taylor sin/cos of one table step
   task automatic build_sine_rom();
      logic [63:0] theta;
      logic [63:0] x2;
      logic [63:0] st;
      logic [63:0] ct;
      logic [63:0] s;
      logic [63:0] c;
      logic [63:0] beta;
      logic [63:0] y1;
      logic [63:0] y2;
      logic [63:0] yn;
      theta = (PI_Q62 + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
      x2    = q61_mul(theta, theta);
      st    = theta;
      ct    = 64'd1 << QBITS;
      s     = theta;
      c     = ct;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         st = q61_mul(st, x2) / 64'((2 * k) * (2 * k + 1));
         ct = q61_mul(ct, x2) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            s = s - st;
            c = c - ct;
         end else begin
            s = s + st;
            c = c + ct;
         end
      end
      beta = c + c;
      sine_rom[0] = '0;
      y2 = '0;
      y1 = s;
      if (TABLE_SIZE > 1) sine_rom[1 % TABLE_SIZE] = q61_to_q15(s);
      for (int i = 2; i < TABLE_SIZE; i++) begin
         yn = q61_smul(beta, y1) - y2;
         sine_rom[i] = q61_to_q15(yn);
         y2 = y1;
         y1 = yn;
      end
   endtask

   function automatic logic signed [SINE_W-1:0] predict_sine(input logic [ANGLE_W-1:0] a);
      longint frac;
      longint idx;
      longint nxt;
      longint s0;
      longint s1;
      longint prod;
      longint mag;
      longint r;
      frac = longint'(a) & ((longint'(1) << ANGLE_FRAC_BITS) - 1);
      idx  = (longint'(a) >> ANGLE_FRAC_BITS) % TABLE_SIZE;
      nxt  = (idx + 1) % TABLE_SIZE;
      s0   = sine_rom[idx];
      s1   = sine_rom[nxt];
      prod = (s1 - s0) * frac;
      mag  = ((prod < 0) ? -prod : prod) + (longint'(1) << (ANGLE_FRAC_BITS - 1));
      mag  = mag >> ANGLE_FRAC_BITS;
      r    = (prod < 0) ? s0 - mag : s0 + mag;
      return SINE_W'(r);
   endfunction

   initial begin
      build_sine_rom();
   end

   always @(posedge clock) begin
      sine_due_type want;
      sine_due_type got;
      if (reset) begin
         sine_due.delete();
         fail_total = 0;
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         // response side first, so a word taken at this edge is never its own match
         if (rsp_valid && rsp_ready) begin
            if (sine_due.size() == 0) begin
               if (fail_total < 10)
                  $display("%0t: response word %0d with nothing outstanding",
                           $realtime, rsp_sine_value);
               fail_total++;
            end else begin
               want = sine_due.pop_front();
               if (rsp_sine_value !== want.sine) begin
                  if (fail_total < 10)
                     $display("%0t: angle %06h sine_value expected %0d got %0d",
                              $realtime, want.angle, want.sine, rsp_sine_value);
                  fail_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            got.angle = req_angle;
            got.sine  = predict_sine(req_angle);
            sine_due.push_back(got);
         end
         fail_count    <= fail_total;
         pending_count <= sine_due.size();
      end
   end

endmodule

// ----- tb/tb_top.sv -----
// Top of the sine table interpolator testbench: clock, reset, angle stimulus and
// response back-pressure. Depends on sti_pkg, sti_req_if, sti_rsp_if and sine_check.
`timescale 1ns / 1ps

module tb_top import sti_pkg::*; ();

   localparam int TABLE_SIZE      = 1024;
   localparam int ANGLE_FRAC_BITS = 14;
   localparam int ITEMS           = 1400;
   localparam int CYCLE_LIMIT     = 800000;
   localparam int TAIL_CYCLES     = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_count;
   int   sent = 0;
   int   calm_left = 0;

   sti_req_if req_chan ();
   sti_rsp_if rsp_chan ();

   sine_table_interpolator #(
      .TABLE_SIZE      (TABLE_SIZE),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sine_check #(
      .TABLE_SIZE      (TABLE_SIZE),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) sine_mon (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_angle      (req_chan.angle),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_sine_value (rsp_chan.sine_value),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // mostly short gaps, now and then a long one, with stretches of none
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_angle(input logic [ANGLE_W-1:0] a);
      int gap;
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.angle <= a;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 150);
         gap = pick_gap();
      end
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         req_chan.angle <= ANGLE_W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // response back-pressure: random runs of ready, a few long stalls, some free stretches
   initial begin
      int hold;
      int r;
      rsp_chan.ready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               rsp_chan.ready <= 1'b1;
               hold = $urandom_range(100, 300);
            end else if (r < 75) begin
               rsp_chan.ready <= 1'($urandom_range(0, 1));
               hold = $urandom_range(0, 2);
            end else if (r < 95) begin
               rsp_chan.ready <= 1'b1;
               hold = $urandom_range(1, 8);
            end else begin
               rsp_chan.ready <= 1'b0;
               hold = $urandom_range(15, 60);
            end
         end
      end
   end

   initial begin
      logic [ANGLE_W-1:0] directed [$];
      logic [ANGLE_W-1:0] phase;
      logic [ANGLE_W-1:0] step;
      logic [ANGLE_W-1:0] frac_pick;
      logic [ANGLE_W-1:0] idx;
      bit                 pressed;
      int                 choice;
      int                 run;

      req_chan.valid = 1'b0;
      req_chan.angle = '0;
      pressed = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero, full turn minus one, quadrant peaks, half-step ties, table wrap, bit patterns
      directed = '{24'h000000, 24'hFFFFFF, 24'h400000, 24'h3FFFFF, 24'h3FE000,
                   24'h402000, 24'h800000, 24'h7FFFFF, 24'h802000, 24'hC00000,
                   24'hBFE000, 24'hC02000, 24'hFFC000, 24'hFFE000, 24'hFFFFFE,
                   24'h000001, 24'h003FFF, 24'h002000, 24'h004000, 24'hAAAAAA,
                   24'h555555, 24'h0F0F0F, 24'hF0F0F0};
      foreach (directed[i]) send_angle(directed[i]);
      drain_results();

      while (sent < ITEMS) begin
         if (!pressed && sent >= ITEMS / 2) begin
            drain_results();
            pressed = 1'b1;
         end
         choice = $urandom_range(0, 99);
         if (choice < 45) begin
            // phase accumulator sweep, wrapping at the full turn
            phase = ANGLE_W'($urandom);
            step  = ($urandom_range(0, 3) == 0) ? ANGLE_W'($urandom)
                                                 : ANGLE_W'($urandom_range(1, 1 << 16));
            run = $urandom_range(8, 40);
            repeat (run) begin
               send_angle(phase);
               phase = phase + step;
            end
         end else if (choice < 70) begin
            send_angle(ANGLE_W'($urandom));
         end else if (choice < 85) begin
            case ($urandom_range(0, 3))
               0: frac_pick = '0;
               1: frac_pick = ANGLE_W'(1);
               2: frac_pick = ANGLE_W'(1) << (ANGLE_FRAC_BITS - 1);
               default: frac_pick = (ANGLE_W'(1) << ANGLE_FRAC_BITS) - 1;
            endcase
            idx = ANGLE_W'($urandom);
            send_angle((idx << ANGLE_FRAC_BITS) | frac_pick);
         end else begin
            // close to a quadrant boundary, either side
            phase = ANGLE_W'($urandom_range(0, 3)) << (ANGLE_W - 2);
            send_angle(phase + ANGLE_W'($urandom_range(0, 1 << 16)) - ANGLE_W'(1 << 15));
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/sti_pkg.sv
rtl/sti_req_if.sv
rtl/sti_rsp_if.sv
rtl/sine_table_interpolator.sv
tb/sine_check.sv
tb/tb_top.sv
